[rtl/tid2ac_pkg.sv]
// ----------------------------------------------------------------------------
// tid2ac_pkg
// Shared types and constants for the tile id to atlas cell unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tid2ac_pkg;

	// tile sets that take part in matching, and map size in cells per axis
	localparam int unsigned NUM_SETS = 4;
	localparam int unsigned MAP_DIM  = 256;

	// storage for set descriptors is always four deep
	localparam int unsigned SET_SLOTS = 4;

	// quotient bits resolved per divider stage; four stages cover 16 bits
	localparam int unsigned DIV_BITS  = 16;
	localparam int unsigned DIV_STEPS = 4;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_SCROLL_X = 3'd0,
		REG_SCROLL_Y = 3'd1,
		REG_SET0     = 3'd2,
		REG_SET1     = 3'd3,
		REG_SET2     = 3'd4,
		REG_SET3     = 3'd5
	} reg_index_t;

	typedef logic [SET_SLOTS-1:0][63:0] desc_array_t;

	// per-item sideband that follows the divider
	typedef struct packed {
		logic [1:0] sel;
		logic [7:0] cols;
		logic [7:0] size;
		logic [7:0] row;
		logic [7:0] col;
	} side_t;

endpackage

`default_nettype wire

[rtl/tid2ac_match.sv]
// ----------------------------------------------------------------------------
// tid2ac_match
// First stage: picks the tile set, forms the local tile number and drops
// empty, off-map and out-of-range cells.
// ----------------------------------------------------------------------------
`default_nettype none

module tid2ac_match #(
	parameter int unsigned NUM_SETS = tid2ac_pkg::NUM_SETS,
	parameter int unsigned MAP_DIM  = tid2ac_pkg::MAP_DIM
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     tile_valid,
	input  logic [15:0]              tile_number,
	input  logic [7:0]               cell_row,
	input  logic [7:0]               cell_column,
	input  tid2ac_pkg::desc_array_t  desc,
	output logic                     valid_s1,
	output tid2ac_pkg::side_t        side_s1,
	output logic [15:0]              dividend_s1
);
	import tid2ac_pkg::*;

	localparam logic [8:0] MAP_LIMIT = 9'(MAP_DIM);

	logic        [1:0]  sel;
	logic signed [17:0] local_num;
	logic        [63:0] chosen;
	logic        [7:0]  cols;
	logic               keep;
	logic signed [17:0] cand;
	logic        [15:0] first_n;
	logic        [15:0] last_n;
	logic        [15:0] count_n;

	// lowest matching set from 1 up wins and set 0 is the default, so scan from the top down
	always_comb begin
		sel       = 2'd0;
		local_num = 18'(tile_number);
		for (int k = SET_SLOTS - 1; k >= 1; k--) begin
			first_n = desc[k][15:0];
			last_n  = desc[k][31:16];
			count_n = desc[k][47:32];
			cand    = 18'(tile_number) + 18'(count_n) - 18'(last_n);
			if (k < NUM_SETS && tile_number >= first_n && tile_number <= last_n) begin
				sel       = 2'(k);
				local_num = cand;
			end
		end
	end

	always_comb begin
		chosen = desc[sel];
		cols   = (chosen[55:48] == 8'd0) ? 8'd1 : chosen[55:48];
		keep   = (tile_number != 16'd0)
			&& ({1'b0, cell_row} < MAP_LIMIT)
			&& ({1'b0, cell_column} < MAP_LIMIT)
			&& (local_num > 18'sd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= tile_valid && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.sel  <= sel;
			side_s1.cols <= cols;
			side_s1.size <= chosen[63:56];
			side_s1.row  <= cell_row;
			side_s1.col  <= cell_column;
			dividend_s1  <= 16'(local_num - 18'sd1);
		end
	end

endmodule

`default_nettype wire

[rtl/tid2ac_div_stage.sv]
// ----------------------------------------------------------------------------
// tid2ac_div_stage
// One registered slice of the restoring divider: resolves DIV_STEPS (four) quotient bits.
// ----------------------------------------------------------------------------
`default_nettype none

module tid2ac_div_stage (
	input  logic        clk,
	input  logic        en,
	input  logic [7:0]  divisor,
	input  logic [7:0]  rem_in,
	input  logic [15:0] work_in,
	output logic [7:0]  rem_out,
	output logic [15:0] work_out
);
	import tid2ac_pkg::*;

	logic [7:0]  rem_q;
	logic [15:0] work_q;
	logic [8:0]  trial;
	logic [7:0]  rem_n;
	logic [15:0] work_n;

	// work shifts the dividend out at the top and the quotient in at the bottom
	always_comb begin
		rem_n  = rem_in;
		work_n = work_in;
		for (int i = 0; i < DIV_STEPS; i++) begin
			trial  = {rem_n, work_n[DIV_BITS-1]};
			work_n = {work_n[DIV_BITS-2:0], 1'b0};
			if (trial >= {1'b0, divisor}) begin
				trial     = trial - {1'b0, divisor};
				work_n[0] = 1'b1;
			end
			rem_n = trial[7:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= rem_n;
			work_q <= work_n;
		end
	end

	assign rem_out  = rem_q;
	assign work_out = work_q;

endmodule

`default_nettype wire

[rtl/tile_id_to_atlas_cell_unit.sv]
// ----------------------------------------------------------------------------
// tile_id_to_atlas_cell_unit
// Pipeline: five register stages (match stage plus four divider stages, each
// resolving 4 quotient bits); the result is presented from the fifth stage.
// Throughput: one map cell per cycle; input stalls only when all five stages
// hold items and the result is not taken.
// Reset: pipeline valid bits and all configuration registers clear to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module tile_id_to_atlas_cell_unit #(
	parameter int unsigned NUM_SETS = tid2ac_pkg::NUM_SETS,
	parameter int unsigned MAP_DIM  = tid2ac_pkg::MAP_DIM
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write,
	input  logic [2:0]          cfg_index,
	input  logic [63:0]         cfg_data,
	input  logic                tile_valid,
	output logic                tile_ready,
	input  logic [15:0]         tile_number,
	input  logic [7:0]          cell_row,
	input  logic [7:0]          cell_column,
	output logic                result_valid,
	input  logic                result_ready,
	output logic [1:0]          set_index,
	output logic [15:0]         atlas_row,
	output logic [7:0]          atlas_column,
	output logic signed [17:0]  screen_x,
	output logic signed [17:0]  screen_y,
	output logic [7:0]          tile_pixels
);
	import tid2ac_pkg::*;

	logic [15:0] scroll_x_q;
	logic [15:0] scroll_y_q;
	desc_array_t desc_q;

	logic        valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic        rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;
	side_t       side_s1, side_s2, side_s3, side_s4, side_s5;
	logic [15:0] dividend_s1;
	logic [7:0]  rem_s2, rem_s3, rem_s4, rem_s5;
	logic [15:0] work_s2, work_s3, work_s4, work_s5;
	logic [15:0] prod_x_s2, prod_y_s2;
	logic signed [17:0] sx_s3, sy_s3, sx_s4, sy_s4, sx_s5, sy_s5;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scroll_x_q <= '0;
			scroll_y_q <= '0;
			desc_q     <= '0;
		end else if (cfg_write) begin
			case (reg_index_t'(cfg_index))
				REG_SCROLL_X: scroll_x_q <= cfg_data[15:0];
				REG_SCROLL_Y: scroll_y_q <= cfg_data[15:0];
				REG_SET0:     desc_q[0]  <= cfg_data;
				REG_SET1:     desc_q[1]  <= cfg_data;
				REG_SET2:     desc_q[2]  <= cfg_data;
				REG_SET3:     desc_q[3]  <= cfg_data;
				default:      ;
			endcase
		end
	end

	// a stage takes new data when it is empty or its successor moves
	assign rdy_s5     = !valid_s5 || result_ready;
	assign rdy_s4     = !valid_s4 || rdy_s5;
	assign rdy_s3     = !valid_s3 || rdy_s4;
	assign rdy_s2     = !valid_s2 || rdy_s3;
	assign rdy_s1     = !valid_s1 || rdy_s2;
	assign tile_ready = rdy_s1;

	tid2ac_match #(
		.NUM_SETS (NUM_SETS),
		.MAP_DIM  (MAP_DIM)
	) u_match (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (rdy_s1),
		.tile_valid  (tile_valid),
		.tile_number (tile_number),
		.cell_row    (cell_row),
		.cell_column (cell_column),
		.desc        (desc_q),
		.valid_s1    (valid_s1),
		.side_s1     (side_s1),
		.dividend_s1 (dividend_s1)
	);

	tid2ac_div_stage u_div_s2 (
		.clk      (clk),
		.en       (rdy_s2),
		.divisor  (side_s1.cols),
		.rem_in   (8'd0),
		.work_in  (dividend_s1),
		.rem_out  (rem_s2),
		.work_out (work_s2)
	);

	tid2ac_div_stage u_div_s3 (
		.clk      (clk),
		.en       (rdy_s3),
		.divisor  (side_s2.cols),
		.rem_in   (rem_s2),
		.work_in  (work_s2),
		.rem_out  (rem_s3),
		.work_out (work_s3)
	);

	tid2ac_div_stage u_div_s4 (
		.clk      (clk),
		.en       (rdy_s4),
		.divisor  (side_s3.cols),
		.rem_in   (rem_s3),
		.work_in  (work_s3),
		.rem_out  (rem_s4),
		.work_out (work_s4)
	);

	tid2ac_div_stage u_div_s5 (
		.clk      (clk),
		.en       (rdy_s5),
		.divisor  (side_s4.cols),
		.rem_in   (rem_s4),
		.work_in  (work_s4),
		.rem_out  (rem_s5),
		.work_out (work_s5)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (rdy_s2) valid_s2 <= valid_s1;
			if (rdy_s3) valid_s3 <= valid_s2;
			if (rdy_s4) valid_s4 <= valid_s3;
			if (rdy_s5) valid_s5 <= valid_s4;
		end
	end

	// screen position: multiply in s2, add scroll in s3
	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			side_s2   <= side_s1;
			prod_x_s2 <= 16'(side_s1.col) * 16'(side_s1.size);
			prod_y_s2 <= 16'(side_s1.row) * 16'(side_s1.size);
		end
		if (rdy_s3) begin
			side_s3 <= side_s2;
			sx_s3   <= 18'(signed'(scroll_x_q)) + signed'({2'b00, prod_x_s2});
			sy_s3   <= 18'(signed'(scroll_y_q)) + signed'({2'b00, prod_y_s2});
		end
		if (rdy_s4) begin
			side_s4 <= side_s3;
			sx_s4   <= sx_s3;
			sy_s4   <= sy_s3;
		end
		if (rdy_s5) begin
			side_s5 <= side_s4;
			sx_s5   <= sx_s4;
			sy_s5   <= sy_s4;
		end
	end

	assign result_valid = valid_s5;
	assign set_index    = side_s5.sel;
	assign atlas_row    = work_s5;
	assign atlas_column = rem_s5;
	assign screen_x     = sx_s5;
	assign screen_y     = sy_s5;
	assign tile_pixels  = side_s5.size;

endmodule

`default_nettype wire
